// ===== hdl/qtc_pkg.sv =====
`default_nettype none
package qtc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int NUM_W  = 128;
  localparam int DEN_W  = 160;
  localparam int REM_W  = 228;
  localparam int WIDE_W = 192;
  localparam int QBITS  = 65;
  localparam int DIV_LAT = QBITS + 2;

  localparam logic REG_TIME_NORM = 1'b0;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] value;
  } coef_res_t;

  function automatic logic [NUM_W-1:0] abs_num(input logic signed [NUM_W-1:0] v);
    abs_num = v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
  endfunction

  // clamp a magnitude with sign to the signed 64-bit range
  function automatic coef_res_t sat64(input logic [WIDE_W-1:0] q, input logic neg);
    coef_res_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (q > WIDE_W'(64'h8000_0000_0000_0000)) begin
        r.sat   = 1'b1;
        r.value = 64'h8000_0000_0000_0000;
      end else begin
        r.value = 64'd0 - q[63:0];
      end
    end else begin
      if (q > WIDE_W'(64'h7FFF_FFFF_FFFF_FFFF)) begin
        r.sat   = 1'b1;
        r.value = 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
        r.value = q[63:0];
      end
    end
    return r;
  endfunction

  // v * 2^sh, rounded half away from zero, saturated
  function automatic coef_res_t rnd_shift(input logic signed [NUM_W-1:0] v, input int sh);
    logic [WIDE_W-1:0] mag;
    logic [WIDE_W-1:0] q;
    mag = WIDE_W'(abs_num(v));
    if (sh >= 0) begin
      q = mag << sh;
    end else begin
      q = (mag + (WIDE_W'(1) << (-sh - 1))) >> (-sh);
    end
    return sat64(q, v[NUM_W-1]);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/qtc_div.sv =====
`default_nettype none
module qtc_div #(
  parameter int REM_W = qtc_pkg::REM_W,
  parameter int DEN_W = qtc_pkg::DEN_W,
  parameter int QB    = qtc_pkg::QBITS
) (
  input  wire                     clk,
  input  wire                     en,
  input  wire [REM_W-1:0]         num,
  input  wire [DEN_W-1:0]         den,
  input  wire                     neg,
  output qtc_pkg::coef_res_t      res
);

  logic [REM_W-1:0] rem [0:QB];
  logic [DEN_W-1:0] dn  [0:QB];
  logic [QB-1:0]    q   [0:QB];
  logic             ng  [0:QB];
  logic             ovf [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dn[0]  <= den;
      q[0]   <= '0;
      ng[0]  <= neg;
      ovf[0] <= num >= (REM_W'(den) << QB);
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [REM_W-1:0] sub;
    logic             ge;
    assign sub = REM_W'(dn[k]) << (QB - 1 - k);
    assign ge  = rem[k] >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - sub : rem[k];
        dn[k+1]  <= dn[k];
        q[k+1]   <= {q[k][QB-2:0], ge};
        ng[k+1]  <= ng[k];
        ovf[k+1] <= ovf[k];
      end
    end
  end

  logic rnd;
  assign rnd = {rem[QB], 1'b0} >= (REM_W+1)'(dn[QB]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf[QB]) begin
        res <= qtc_pkg::sat64({qtc_pkg::WIDE_W{1'b1}}, ng[QB]);
      end else begin
        res <= qtc_pkg::sat64(qtc_pkg::WIDE_W'(q[QB]) + qtc_pkg::WIDE_W'(rnd), ng[QB]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/quintic_trajectory_coefficients_unit.sv =====
// An input transaction reaches the result through 8 arithmetic stages, 67 divider
// stages and 1 output register. Throughput: one transaction per cycle; the three
// t^5..t^3 dividers are bit-per-stage pipelines. The whole pipeline holds while a
// result waits at the output. Reset clears all valid bits and time_normalized.
`default_nettype none
module quintic_trajectory_coefficients_unit #(
  parameter int FRAC_BITS = qtc_pkg::FRAC_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  wire          s_tvalid,
  output logic         s_tready,
  // start_pos, start_vel, start_acc, end_pos, end_vel, end_acc, duration
  input  wire  [223:0] s_tdata,
  output logic         m_tvalid,
  input  wire          m_tready,
  // coef_t5, coef_t4, coef_t3, coef_t2, coef_t1, coef_t0, status, zero pad
  output logic [391:0] m_tdata
);

  localparam int NW = qtc_pkg::NUM_W;
  localparam int RW = qtc_pkg::REM_W;
  localparam int DW = qtc_pkg::DEN_W;
  localparam int DL = qtc_pkg::DIV_LAT;
  localparam int HW = 70;
  localparam int BW = 104;
  localparam int S  = 2 * FRAC_BITS + 1;

  logic time_norm;
  logic en;

  assign pready   = 1'b1;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign prdata   = (paddr[2] == qtc_pkg::REG_TIME_NORM) ? {31'd0, time_norm} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_norm <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == qtc_pkg::REG_TIME_NORM) begin
      time_norm <= pwdata[0];
    end
  end

  // stage A
  logic signed [31:0] a_p0, a_v0, a_a0, a_p1, a_v1, a_a1;
  logic [31:0]        a_d;
  // stage B
  logic [63:0]        b_d2;
  logic signed [64:0] b_v0d;
  logic signed [32:0] b_dp;
  logic signed [34:0] b_k25, b_k24, b_k23;
  logic signed [37:0] b_k15, b_k14, b_k13;
  logic [31:0]        b_d;
  logic signed [31:0] b_a0, b_v0, b_p0, b_p1, b_v1, b_a1;
  logic               b_zero;
  // stage C
  logic signed [67:0] c_k2d5, c_k2d4, c_k2d3;
  logic [63:0]        c_d3hi, c_d3lo;
  logic signed [64:0] c_a0d2hi, c_a0d2lo;
  logic signed [37:0] c_k15, c_k14, c_k13;
  logic signed [32:0] c_dp;
  logic [31:0]        c_d;
  logic signed [64:0] c_v0d;
  logic signed [31:0] c_a0, c_v0, c_p0, c_p1, c_v1, c_a1;
  logic               c_zero;
  // stage D
  logic signed [HW-1:0] d_h5, d_h4, d_h3;
  logic [95:0]          d_d3;
  logic signed [96:0]   d_c2u;
  logic signed [32:0]   d_dp;
  logic [31:0]          d_d;
  logic signed [64:0]   d_v0d;
  logic signed [31:0]   d_a0, d_v0, d_p0, d_p1, d_v1, d_a1;
  logic                 d_zero;
  // stage E
  logic [63:0]          e_hlo5, e_hlo4, e_hlo3;
  logic signed [70:0]   e_hhi5, e_hhi4, e_hhi3;
  logic [63:0]          e_d4p0, e_d4p1, e_d4p2;
  logic signed [BW-1:0] e_b0, e_b1, e_b2;
  logic signed [32:0]   e_dp;
  logic [31:0]          e_d;
  logic [95:0]          e_d3;
  logic signed [64:0]   e_v0d;
  logic signed [96:0]   e_c2u;
  logic signed [31:0]   e_a0, e_v0, e_p0;
  logic                 e_zero;
  // stage F
  logic signed [NW-1:0] f_dh5, f_dh4, f_dh3;
  logic [127:0]         f_d4;
  logic signed [NW-1:0] f_x5, f_x4, f_x3;
  logic signed [32:0]   f_dp;
  logic [31:0]          f_d;
  logic [95:0]          f_d3;
  logic signed [64:0]   f_v0d;
  logic signed [96:0]   f_c2u;
  logic signed [31:0]   f_a0, f_v0, f_p0;
  logic                 f_zero;
  // stage G
  logic signed [NW-1:0] g_n5, g_n4, g_n3;
  logic [63:0]          g_q0, g_q1, g_q2, g_q3;
  logic signed [NW-1:0] g_x5, g_x4, g_x3;
  logic [95:0]          g_d3;
  logic [127:0]         g_d4;
  logic signed [64:0]   g_v0d;
  logic signed [96:0]   g_c2u;
  logic signed [31:0]   g_a0, g_v0, g_p0;
  logic                 g_zero;
  // stage H
  logic [RW-1:0]        h_num5, h_num4, h_num3;
  logic [DW-1:0]        h_den5, h_den4, h_den3;
  logic                 h_neg5, h_neg4, h_neg3;
  qtc_pkg::coef_res_t   h_t2, h_t1, h_t0;
  logic                 h_zero;

  logic [DW-1:0] g_d5;
  assign g_d5 = (DW'(g_q3) << 96) + (DW'(g_q2) << 64) + (DW'(g_q1) << 32) + DW'(g_q0);

  always_ff @(posedge clk) begin
    if (en) begin
      a_p0 <= s_tdata[31:0];
      a_v0 <= s_tdata[63:32];
      a_a0 <= s_tdata[95:64];
      a_p1 <= s_tdata[127:96];
      a_v1 <= s_tdata[159:128];
      a_a1 <= s_tdata[191:160];
      a_d  <= s_tdata[223:192];

      b_d2   <= a_d * a_d;
      b_v0d  <= a_v0 * $signed({1'b0, a_d});
      b_dp   <= 33'(a_p1) - 33'(a_p0);
      b_k25  <= 35'(a_a1) - 35'(a_a0);
      b_k24  <= 35'(a_a0) * 35'sd3 - 35'(a_a1) * 35'sd2;
      b_k23  <= 35'(a_a1) - 35'(a_a0) * 35'sd3;
      b_k15  <= -((38'(a_v0) + 38'(a_v1)) * 38'sd6);
      b_k14  <= 38'(a_v0) * 38'sd16 + 38'(a_v1) * 38'sd14;
      b_k13  <= -(38'(a_v0) * 38'sd12 + 38'(a_v1) * 38'sd8);
      b_d    <= a_d;
      b_a0   <= a_a0;
      b_v0   <= a_v0;
      b_p0   <= a_p0;
      b_p1   <= a_p1;
      b_v1   <= a_v1;
      b_a1   <= a_a1;
      b_zero <= a_d == 32'd0;

      c_k2d5   <= b_k25 * $signed({1'b0, b_d});
      c_k2d4   <= b_k24 * $signed({1'b0, b_d});
      c_k2d3   <= b_k23 * $signed({1'b0, b_d});
      c_d3hi   <= b_d2[63:32] * b_d;
      c_d3lo   <= b_d2[31:0] * b_d;
      c_a0d2hi <= b_a0 * $signed({1'b0, b_d2[63:32]});
      c_a0d2lo <= b_a0 * $signed({1'b0, b_d2[31:0]});
      c_k15    <= b_k15;
      c_k14    <= b_k14;
      c_k13    <= b_k13;
      c_dp     <= b_dp;
      c_d      <= b_d;
      c_v0d    <= b_v0d;
      c_a0     <= b_a0;
      c_v0     <= b_v0;
      c_p0     <= b_p0;
      c_p1     <= b_p1;
      c_v1     <= b_v1;
      c_a1     <= b_a1;
      c_zero   <= b_zero;

      d_h5   <= (HW'(c_k15) <<< FRAC_BITS) + HW'(c_k2d5);
      d_h4   <= (HW'(c_k14) <<< FRAC_BITS) + HW'(c_k2d4);
      d_h3   <= (HW'(c_k13) <<< FRAC_BITS) + HW'(c_k2d3);
      d_d3   <= (96'(c_d3hi) << 32) + 96'(c_d3lo);
      d_c2u  <= (97'(c_a0d2hi) <<< 32) + 97'(c_a0d2lo);
      d_dp   <= c_dp;
      d_d    <= c_d;
      d_v0d  <= c_v0d;
      d_a0   <= c_a0;
      d_v0   <= c_v0;
      d_p0   <= c_p0;
      d_p1   <= c_p1;
      d_v1   <= c_v1;
      d_a1   <= c_a1;
      d_zero <= c_zero;

      e_hlo5 <= d_h5[31:0] * d_d;
      e_hlo4 <= d_h4[31:0] * d_d;
      e_hlo3 <= d_h3[31:0] * d_d;
      e_hhi5 <= $signed(d_h5[HW-1:32]) * $signed({1'b0, d_d});
      e_hhi4 <= $signed(d_h4[HW-1:32]) * $signed({1'b0, d_d});
      e_hhi3 <= $signed(d_h3[HW-1:32]) * $signed({1'b0, d_d});
      e_d4p0 <= d_d3[31:0] * d_d;
      e_d4p1 <= d_d3[63:32] * d_d;
      e_d4p2 <= d_d3[95:64] * d_d;
      e_b0   <= (BW'(d_p1) <<< S) - (BW'(d_p0) <<< S) - (BW'(d_v0d) <<< (FRAC_BITS + 1))
                - BW'(d_c2u);
      e_b1   <= (BW'(d_v1) <<< S) - (BW'(d_v0d) <<< (FRAC_BITS + 1)) - (BW'(d_c2u) <<< 1);
      e_b2   <= (BW'(d_a1) <<< S) - (BW'(d_c2u) <<< 1);
      e_dp   <= d_dp;
      e_d    <= d_d;
      e_d3   <= d_d3;
      e_v0d  <= d_v0d;
      e_c2u  <= d_c2u;
      e_a0   <= d_a0;
      e_v0   <= d_v0;
      e_p0   <= d_p0;
      e_zero <= d_zero;

      f_dh5  <= (NW'(e_hhi5) <<< 32) + $signed(NW'(e_hlo5));
      f_dh4  <= (NW'(e_hhi4) <<< 32) + $signed(NW'(e_hlo4));
      f_dh3  <= (NW'(e_hhi3) <<< 32) + $signed(NW'(e_hlo3));
      f_d4   <= (128'(e_d4p2) << 64) + (128'(e_d4p1) << 32) + 128'(e_d4p0);
      f_x5   <= NW'(e_b0) * 12 - NW'(e_b1) * 6 + NW'(e_b2);
      f_x4   <= NW'(e_b1) * 7 - NW'(e_b0) * 15 - NW'(e_b2);
      f_x3   <= NW'(e_b0) * 20 - NW'(e_b1) * 8 + NW'(e_b2);
      f_dp   <= e_dp;
      f_d    <= e_d;
      f_d3   <= e_d3;
      f_v0d  <= e_v0d;
      f_c2u  <= e_c2u;
      f_a0   <= e_a0;
      f_v0   <= e_v0;
      f_p0   <= e_p0;
      f_zero <= e_zero;

      g_n5   <= (NW'(f_dp) <<< (2 * FRAC_BITS)) * 12 + f_dh5;
      g_n4   <= (NW'(f_dp) <<< (2 * FRAC_BITS)) * (-30) + f_dh4;
      g_n3   <= (NW'(f_dp) <<< (2 * FRAC_BITS)) * 20 + f_dh3;
      g_q0   <= f_d4[31:0] * f_d;
      g_q1   <= f_d4[63:32] * f_d;
      g_q2   <= f_d4[95:64] * f_d;
      g_q3   <= f_d4[127:96] * f_d;
      g_x5   <= f_x5;
      g_x4   <= f_x4;
      g_x3   <= f_x3;
      g_d3   <= f_d3;
      g_d4   <= f_d4;
      g_v0d  <= f_v0d;
      g_c2u  <= f_c2u;
      g_a0   <= f_a0;
      g_v0   <= f_v0;
      g_p0   <= f_p0;
      g_zero <= f_zero;

      if (time_norm) begin
        h_num5 <= RW'(qtc_pkg::abs_num(g_x5)) << 32;
        h_num4 <= RW'(qtc_pkg::abs_num(g_x4)) << 32;
        h_num3 <= RW'(qtc_pkg::abs_num(g_x3)) << 32;
        h_den5 <= DW'(1) << (3 * FRAC_BITS + 2);
        h_den4 <= DW'(1) << (3 * FRAC_BITS + 1);
        h_den3 <= DW'(1) << (3 * FRAC_BITS + 2);
        h_neg5 <= g_x5[NW-1];
        h_neg4 <= g_x4[NW-1];
        h_neg3 <= g_x3[NW-1];
        h_t2   <= qtc_pkg::rnd_shift(NW'(g_c2u), 31 - 3 * FRAC_BITS);
        h_t1   <= qtc_pkg::rnd_shift(NW'(g_v0d), 32 - 2 * FRAC_BITS);
      end else begin
        h_num5 <= RW'(qtc_pkg::abs_num(g_n5)) << (2 * FRAC_BITS + 31);
        h_num4 <= RW'(qtc_pkg::abs_num(g_n4)) << (FRAC_BITS + 31);
        h_num3 <= RW'(qtc_pkg::abs_num(g_n3)) << 31;
        h_den5 <= g_d5;
        h_den4 <= DW'(g_d4);
        h_den3 <= DW'(g_d3);
        h_neg5 <= g_n5[NW-1];
        h_neg4 <= g_n4[NW-1];
        h_neg3 <= g_n3[NW-1];
        h_t2   <= qtc_pkg::rnd_shift(NW'(g_a0), 31 - FRAC_BITS);
        h_t1   <= qtc_pkg::rnd_shift(NW'(g_v0), 32 - FRAC_BITS);
      end
      h_t0   <= qtc_pkg::rnd_shift(NW'(g_p0), 32 - FRAC_BITS);
      h_zero <= g_zero;
    end
  end

  qtc_pkg::coef_res_t r5, r4, r3;

  qtc_div #(.REM_W(RW), .DEN_W(DW), .QB(qtc_pkg::QBITS)) u_div5 (
    .clk(clk), .en(en), .num(h_num5), .den(h_den5), .neg(h_neg5), .res(r5)
  );
  qtc_div #(.REM_W(RW), .DEN_W(DW), .QB(qtc_pkg::QBITS)) u_div4 (
    .clk(clk), .en(en), .num(h_num4), .den(h_den4), .neg(h_neg4), .res(r4)
  );
  qtc_div #(.REM_W(RW), .DEN_W(DW), .QB(qtc_pkg::QBITS)) u_div3 (
    .clk(clk), .en(en), .num(h_num3), .den(h_den3), .neg(h_neg3), .res(r3)
  );

  qtc_pkg::coef_res_t dl_t2 [0:DL-1];
  qtc_pkg::coef_res_t dl_t1 [0:DL-1];
  qtc_pkg::coef_res_t dl_t0 [0:DL-1];
  logic               dl_zero [0:DL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dl_t2[0]   <= h_t2;
      dl_t1[0]   <= h_t1;
      dl_t0[0]   <= h_t0;
      dl_zero[0] <= h_zero;
      for (int i = 1; i < DL; i++) begin
        dl_t2[i]   <= dl_t2[i-1];
        dl_t1[i]   <= dl_t1[i-1];
        dl_t0[i]   <= dl_t0[i-1];
        dl_zero[i] <= dl_zero[i-1];
      end
    end
  end

  // valid bits
  logic [7:0]    vld;
  logic [DL-1:0] dl_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      dl_v     <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[6:0], s_tvalid};
      dl_v     <= {dl_v[DL-2:0], vld[7]};
      m_tvalid <= dl_v[DL-1];
    end
  end

  logic [63:0]      coef_t5, coef_t4, coef_t3, coef_t2, coef_t1, coef_t0;
  qtc_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (en) begin
      if (dl_zero[DL-1]) begin
        coef_t5 <= '0;
        coef_t4 <= '0;
        coef_t3 <= '0;
        coef_t2 <= '0;
        coef_t1 <= '0;
        coef_t0 <= '0;
        status  <= qtc_pkg::ST_ZERO;
      end else begin
        coef_t5 <= r5.value;
        coef_t4 <= r4.value;
        coef_t3 <= r3.value;
        coef_t2 <= dl_t2[DL-1].value;
        coef_t1 <= dl_t1[DL-1].value;
        coef_t0 <= dl_t0[DL-1].value;
        status  <= (r5.sat || r4.sat || r3.sat || dl_t2[DL-1].sat || dl_t1[DL-1].sat
                    || dl_t0[DL-1].sat) ? qtc_pkg::ST_SAT : qtc_pkg::ST_OK;
      end
    end
  end

  assign m_tdata = {6'd0, status, coef_t0, coef_t1, coef_t2, coef_t3, coef_t4, coef_t5};

endmodule
`default_nettype wire

// ===== tb/sv/quintic_trajectory_coefficients_unit_tb.sv =====
`timescale 1ns / 1ps
module quintic_trajectory_coefficients_unit_tb;

  localparam int F = qtc_pkg::FRAC_BITS_DEF;
  localparam int SETTLE = 100;

  typedef logic signed [255:0] big_t;

  typedef struct {
    logic [31:0] sp, sv, sa, ep, ev, ea, dur;
  } segment_t;

  typedef struct {
    logic [63:0]      c[6];
    qtc_pkg::status_t st;
  } coefs_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  wire [31:0] prdata;
  wire pready;
  logic s_tvalid = 0;
  wire s_tready;
  logic [223:0] s_tdata = 0;
  wire m_tvalid;
  logic m_tready = 0;
  wire [391:0] m_tdata;

  quintic_trajectory_coefficients_unit uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  segment_t pending_segs[$];
  coefs_t   expected_coefs[$];
  logic     norm_mode = 0;
  int       send_idle = 15, recv_idle = 52;
  int       errors = 0, n_sent = 0, n_checked = 0, n_zero = 0, n_sat = 0;

  initial forever #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("quintic_trajectory_coefficients_unit verification failed");
    $finish;
  end

  function automatic logic [63:0] round_div(big_t num, int sh, big_t den, inout logic sat);
    logic neg;
    logic [255:0] mag, q, r, ud;
    neg = num < 0;
    mag = neg ? -num : num;
    mag = mag << sh;
    ud = den;
    q = mag / ud;
    r = mag % ud;
    if ((r << 1) >= ud) q = q + 1;
    if (neg) begin
      if (q > 256'h8000_0000_0000_0000) begin
        sat = 1;
        return 64'h8000_0000_0000_0000;
      end
      return 64'd0 - q[63:0];
    end
    if (q > 256'h7FFF_FFFF_FFFF_FFFF) begin
      sat = 1;
      return 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return q[63:0];
  endfunction

  function automatic coefs_t predict_coefs(segment_t s, logic nm);
    coefs_t o;
    big_t p0, v0, a0, p1, v1, a1, d, d2, d3, d4, d5;
    big_t c0u, c1u, c2u, b0, b1, b2, b1d, b2d2, n5, n4, n3, one;
    logic sat;
    int sh;
    sat = 0;
    one = 1;
    p0 = $signed(s.sp); v0 = $signed(s.sv); a0 = $signed(s.sa);
    p1 = $signed(s.ep); v1 = $signed(s.ev); a1 = $signed(s.ea);
    d = {224'd0, s.dur};
    d2 = d * d;
    if (s.dur == 0) begin
      foreach (o.c[j]) o.c[j] = 0;
      o.st = qtc_pkg::ST_ZERO;
      return o;
    end
    if (nm) begin
      sh = 2 * F + 1;
      c0u = p0 << sh;
      c1u = (2 * v0 * d) << F;
      c2u = a0 * d2;
      b0 = (p1 << sh) - c0u - c1u - c2u;
      b1 = (v1 << sh) - c1u - 2 * c2u;
      b2 = (a1 << sh) - 2 * c2u;
      o.c[0] = round_div(12 * b0 - 6 * b1 + b2, 32, one << (3 * F + 2), sat);
      o.c[1] = round_div(-15 * b0 + 7 * b1 - b2, 32, one << (3 * F + 1), sat);
      o.c[2] = round_div(20 * b0 - 8 * b1 + b2, 32, one << (3 * F + 2), sat);
      o.c[3] = round_div(c2u, 32, one << (3 * F + 1), sat);
      o.c[4] = round_div(c1u, 32, one << (3 * F + 1), sat);
      o.c[5] = round_div(c0u, 32, one << (3 * F + 1), sat);
    end else begin
      d3 = d2 * d; d4 = d3 * d; d5 = d4 * d;
      b0 = ((2 * (p1 - p0)) << (2 * F)) - ((2 * v0 * d) << F) - a0 * d2;
      b1 = ((v1 - v0) << F) - a0 * d;
      b2 = a1 - a0;
      b1d = b1 * d;
      b2d2 = b2 * d2;
      n5 = 6 * b0 - 6 * b1d + b2d2;
      n4 = -15 * b0 + 14 * b1d - 2 * b2d2;
      n3 = 10 * b0 - 8 * b1d + b2d2;
      o.c[0] = round_div(n5, 2 * F + 32, 2 * d5, sat);
      o.c[1] = round_div(n4, F + 32, 2 * d4, sat);
      o.c[2] = round_div(n3, 32, 2 * d3, sat);
      o.c[3] = round_div(a0, 32, one << (F + 1), sat);
      o.c[4] = round_div(v0, 32, one << F, sat);
      o.c[5] = round_div(p0, 32, one << F, sat);
    end
    o.st = sat ? qtc_pkg::ST_SAT : qtc_pkg::ST_OK;
    return o;
  endfunction

  // driver
  logic took;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !took) begin
      end else if (pending_segs.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_tvalid <= 1;
        s_tdata <= {pending_segs[0].dur, pending_segs[0].ea, pending_segs[0].ev,
                    pending_segs[0].ep, pending_segs[0].sa, pending_segs[0].sv,
                    pending_segs[0].sp};
      end else begin
        s_tvalid <= 0;
      end
      m_tready <= $urandom_range(99) >= recv_idle;
    end
  end

  // monitor
  always @(posedge clk) begin
    took <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_coefs.push_back(predict_coefs(pending_segs.pop_front(), norm_mode));
      n_sent++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_coefs.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, m_tdata);
        errors++;
      end else begin
        coefs_t e;
        e = expected_coefs.pop_front();
        n_checked++;
        if (e.st == qtc_pkg::ST_ZERO) n_zero++;
        if (e.st == qtc_pkg::ST_SAT) n_sat++;
        for (int j = 0; j < 6; j++)
          if (m_tdata[64*j +: 64] !== e.c[j]) begin
            $display("%0t: coef_t%0d expected %h actual %h", $time, 5 - j, e.c[j],
                     m_tdata[64*j +: 64]);
            errors++;
          end
        if (m_tdata[385:384] !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, m_tdata[385:384]);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == 0) norm_mode = val[0];
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain;
    while (pending_segs.size() > 0 || expected_coefs.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_val();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_dur();
    case ($urandom_range(19))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 16);
      3, 4, 5: return $urandom;
      default: return $urandom_range(32'h0000_4000, 32'h0008_0000);
    endcase
  endfunction

  task automatic add_seg(logic [31:0] sp, sv, sa, ep, ev, ea, dur);
    segment_t s;
    s.sp = sp; s.sv = sv; s.sa = sa; s.ep = ep; s.ev = ev; s.ea = ea; s.dur = dur;
    pending_segs.push_back(s);
  endtask

  task automatic add_directed;
    add_seg(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000);
    add_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 1);
    add_seg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'hFFFF_FFFF);
    add_seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
    add_seg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'h0000_8000);
    add_seg(32'h0002_0000, 32'h0000_8000, 32'hFFFF_0000, 32'hFFFE_0000, 32'h0001_0000,
            32'h0000_4000, 32'h0002_0000);
    add_seg(0, 0, 0, 0, 0, 0, 0);
    add_seg(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    add_directed();
    drain();
    reg_write(3'd4, 32'hFFFF_FFFF);
    add_directed();
    drain();
    reg_write(3'd0, 32'h0000_0001);
    add_directed();
    drain();
    for (int blk = 0; blk < 6; blk++) begin
      send_idle = (blk < 2) ? 15 : (blk < 4) ? 52 : 0;
      recv_idle = (blk < 2) ? 52 : (blk < 4) ? 15 : 0;
      reg_write(3'd0, {31'($urandom_range(32'h7FFF_FFFF)), blk[0]});
      for (int k = 0; k < 205; k++) begin
        add_seg(pick_val(), pick_val(), pick_val(), pick_val(), pick_val(), pick_val(),
                pick_dur());
        if (k == 100) drain();
      end
      drain();
    end
    $display("covered %0d segments in both time modes, %0d zero duration, %0d saturated",
             n_checked, n_zero, n_sat);
    if (errors == 0 && n_checked == n_sent)
      $display("quintic_trajectory_coefficients_unit verification clean");
    else
      $display("quintic_trajectory_coefficients_unit verification failed");
    $finish;
  end
endmodule
